>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge, muted in reset.
`define CHK_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// Implication checked with a non-overlapping consequent.
`define CHK_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`endif

>>> rtl/vhpc_pkg.sv
// ---------------------------------------------------------------------------
// vhpc_pkg
// Types, constants and syntax tables of the video header parse/check block.
// ---------------------------------------------------------------------------
`default_nettype none
package vhpc_pkg;
   localparam int GolombMaxZeros = 16;
   localparam int QDepth = 2;

   localparam logic [1:0] KIND_SEQ   = 2'd0;
   localparam logic [1:0] KIND_IPIC  = 2'd1;
   localparam logic [1:0] KIND_PBPIC = 2'd2;
   localparam logic [1:0] KIND_SLICE = 2'd3;

   localparam logic [5:0] W_ABSENT = 6'd0;
   localparam logic [5:0] W_UE     = 6'd63;
   localparam logic [5:0] W_END    = 6'd62;

   localparam int ERR_TIMECODE = 10;
   localparam int ERR_REFFLAG  = 11;
   localparam int ERR_ROW      = 12;
   localparam int ERR_GOLOMB   = 13;
   localparam int ERR_TRUNC    = 14;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [9:0]  row;
   } item_type;

   typedef struct packed {
      logic        is_verdict;
      logic [4:0]  id;
      logic [31:0] value;
      logic        hvalid;
      logic [14:0] flags;
      logic        last;
   } result_type;

   function automatic logic [5:0] table_width(input logic [1:0] kind,
                                              input logic [4:0] pos);
      logic [5:0] w;
      w = W_END;
      case (kind)
         KIND_SEQ: begin
            case (pos)
               5'd0, 5'd1: w = 6'd8;
               5'd2, 5'd3: w = 6'd14;
               5'd4: w = 6'd2;
               5'd5: w = 6'd3;
               5'd6, 5'd7, 5'd16: w = 6'd4;
               5'd8, 5'd13: w = 6'd18;
               5'd9, 5'd11, 5'd12, 5'd14, 5'd15: w = 6'd1;
               5'd10: w = 6'd12;
               default: w = W_END;
            endcase
         end
         KIND_IPIC: begin
            case (pos)
               5'd0: w = 6'd16;
               5'd1, 5'd3, 5'd6, 5'd9: w = 6'd1;
               5'd2: w = 6'd24;
               5'd4, 5'd10: w = 6'd8;
               5'd5: w = W_UE;
               5'd7, 5'd11: w = 6'd6;
               5'd8: w = 6'd4;
               default: w = W_END;
            endcase
         end
         KIND_PBPIC: begin
            case (pos)
               5'd0: w = 6'd16;
               5'd1, 5'd2: w = 6'd2;
               5'd3, 5'd10: w = 6'd8;
               5'd4: w = W_UE;
               5'd5, 5'd7, 5'd9: w = 6'd1;
               5'd6, 5'd11: w = 6'd6;
               5'd8: w = 6'd3;
               default: w = W_END;
            endcase
         end
         default: begin
            case (pos)
               5'd0: w = 6'd8;
               5'd1: w = 6'd3;
               5'd2: w = 6'd1;
               5'd3: w = 6'd6;
               default: w = W_END;
            endcase
         end
      endcase
      return w;
   endfunction
endpackage
`default_nettype wire

>>> rtl/video_header_parse_check_unit.sv
// Video header parse/check unit.
// req_ channel: one transaction per header payload byte, with kind, first and
// last marks and the expected macroblock row. rsp_ channel: element results
// (id, value) and, after a last byte, one verdict with error flags.
// An item waits in a two-entry queue; the back end takes it from the idle state
// and then walks its 8 bits at one bit per cycle while rsp_ is not stalled,
// plus a step per skipped absent element. A last byte then yields the
// verdict, with a parked element result going out ahead of it.
// An element result is parked until the next result of the same byte or the
// end of the byte; after a non-last byte it leaves from the idle state with
// last_result set, while on a last byte the verdict carries last_result.
// The output register holds a result while rsp_stall is high and the walker
// pauses; the queue keeps taking bytes until full. Synchronous active-high
// reset empties the queue, clears the parse position and kept sequence
// values; kept 18-bit header fields are undefined until written.
// The bit walker (one bit per cycle) sets the rate.
// ---------------------------------------------------------------------------
// video_header_parse_check_unit
// Top level: queue front end plus bit-serial parse/check back end.
// ---------------------------------------------------------------------------
`default_nettype none
module video_header_parse_check_unit import vhpc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_header_kind,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_last_byte,
   input  wire logic [9:0]  req_expected_mb_row,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_is_verdict,
   output logic [4:0]       rsp_element_id,
   output logic [31:0]      rsp_element_value,
   output logic             rsp_header_valid,
   output logic [14:0]      rsp_error_flags,
   output logic             rsp_last_result
);
   item_type   in_item, q_item;
   logic       q_valid, q_take;
   result_type res;

   assign in_item = '{kind: req_header_kind, data: req_data_byte,
                      first: req_first_byte, last: req_last_byte,
                      row: req_expected_mb_row};

   vhpc_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall),
      .in_item, .q_valid, .q_take, .q_item
   );

   vhpc_back u_back (
      .clock, .reset, .q_valid, .q_take, .q_item,
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_res(res)
   );

   assign rsp_is_verdict    = res.is_verdict;
   assign rsp_element_id    = res.id;
   assign rsp_element_value = res.value;
   assign rsp_header_valid  = res.hvalid;
   assign rsp_error_flags   = res.flags;
   assign rsp_last_result   = res.last;
endmodule
`default_nettype wire

>>> rtl/vhpc_front.sv
// ---------------------------------------------------------------------------
// vhpc_front
// Input stage and item queue: takes transactions and buffers them for the
// bit-serial back end.
// ---------------------------------------------------------------------------
`default_nettype none
module vhpc_front import vhpc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_stall,
   input  wire item_type in_item,
   output logic          q_valid,
   input  wire logic     q_take,
   output item_type      q_item
);
   item_type   mem_ff [QDepth];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign in_stall = (cnt_ff == 2'(QDepth));
   assign push     = in_valid && !in_stall;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ (q_take && q_valid);
      cnt_in = cnt_ff + 2'(push) - 2'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule
`default_nettype wire

>>> rtl/vhpc_back.sv
// ---------------------------------------------------------------------------
// vhpc_back
// Bit-serial syntax walker: one bit per cycle while the output register is
// free, emits element results and the end-of-header verdict into an output register.
// ---------------------------------------------------------------------------
`default_nettype none
module vhpc_back import vhpc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   output logic          q_take,
   input  wire item_type q_item,
   output logic          out_valid,
   input  wire logic     out_stall,
   output result_type    out_res
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_BITS = 3'b010,
      ST_VERD = 3'b100
   } state_type;

   state_type   st_ff, st_in;
   item_type    it_ff, it_in;
   logic [2:0]  bit_ff, bit_in;
   logic [4:0]  idx_ff, idx_in;
   logic [5:0]  bg_ff, bg_in;
   logic [31:0] acc_ff, acc_in;
   logic [4:0]  gz_ff, gz_in;
   logic        ld_ff, ld_in;
   logic [13:0] ht_ff, ht_in;
   logic [7:0]  lvl_ff, lvl_in;
   logic        fqp_ff, fqp_in;
   logic [14:0] err_ff, err_in;
   logic        hot_ff, hot_in;   // height above 2800, registered
   logic [17:0] held_ff [8];
   logic        hw_en;
   logic [2:0]  hw_addr;
   logic [17:0] hw_data;
   logic        ov_ff, ov_in;
   result_type  res_ff, res_in;
   // element result parked until the next result of the same byte, or the
   // end of the byte, tells whether it is the byte's last one
   logic        pend_ff, pend_in;
   result_type  pres_ff, pres_in;

   logic        out_free;
   logic [5:0]  w;
   logic        bitv, done;
   logic [31:0] val;
   logic [14:0] flags;
   logic [10:0] srow;
   logic [31:0] wlim, hlim, blim;

   // Effective width with conditional elements; absent elements are skipped
   // one position per cycle; during the bit walk only while the output is free.
   function automatic logic [5:0] eff_width(input logic [1:0] k, input logic [4:0] p);
      logic [5:0] tw;
      tw = table_width(k, p);
      case (k)
         KIND_IPIC: begin
            if (p == 5'd2 && held_ff[0] == 18'd0) tw = W_ABSENT;
            if (p == 5'd5 && !ld_ff) tw = W_ABSENT;
            if ((p == 5'd10 || p == 5'd11) && held_ff[1] != 18'd0) tw = W_ABSENT;
         end
         KIND_PBPIC: begin
            if (p == 5'd4 && !ld_ff) tw = W_ABSENT;
            if ((p == 5'd10 || p == 5'd11) && held_ff[1] != 18'd0) tw = W_ABSENT;
         end
         KIND_SLICE: begin
            if (p == 5'd1 && !hot_ff) tw = W_ABSENT;
            if ((p == 5'd2 || p == 5'd3) && fqp_ff) tw = W_ABSENT;
         end
         default: tw = tw;
      endcase
      return tw;
   endfunction

   assign out_free  = !ov_ff || !out_stall;
   assign w         = eff_width(it_ff.kind, idx_ff);
   assign bitv      = it_ff.data[bit_ff];
   assign q_take    = (st_ff == ST_IDLE) && out_free;
   assign out_valid = ov_ff;
   assign out_res   = res_ff;

   always_comb begin
      st_in = st_ff; it_in = it_ff; bit_in = bit_ff; idx_in = idx_ff;
      bg_in = bg_ff; acc_in = acc_ff; gz_in = gz_ff; ld_in = ld_ff;
      ht_in = ht_ff; lvl_in = lvl_ff; fqp_in = fqp_ff; err_in = err_ff;
      ov_in = ov_ff && out_stall; res_in = res_ff;
      pend_in = pend_ff; pres_in = pres_ff;
      hw_en = 1'b0; hw_addr = 3'd0; hw_data = 18'd0;
      done = 1'b0; val = 32'd0; flags = err_ff; srow = 11'd0;
      wlim = 32'd0; hlim = 32'd0; blim = 32'd0;
      hot_in = (ht_ff > 14'd2800);
      case (st_ff)
         ST_IDLE: begin
            if (out_free) begin
               // parked result closes the previous byte
               if (pend_ff) begin
                  ov_in = 1'b1;
                  res_in = pres_ff;
                  res_in.last = 1'b1;
                  pend_in = 1'b0;
               end
               if (q_valid) begin
                  it_in = q_item; bit_in = 3'd7;
                  st_in = ST_BITS;
                  if (q_item.first) begin
                     idx_in = 5'd0; bg_in = 6'd0; acc_in = 32'd0; gz_in = 5'd0;
                     err_in = 15'd0;
                  end
               end
            end
         end
         ST_BITS: begin
            if (out_free) begin
               if (w == W_ABSENT) begin
                  idx_in = idx_ff + 5'd1;
               end else begin
                  if (w == W_UE) begin
                     if (acc_ff == 32'd0) begin
                        if (bitv) begin
                           acc_in = 32'd1;
                           if (gz_ff == 5'd0) done = 1'b1;
                        end else if (gz_ff >= 5'(GolombMaxZeros)) begin
                           done = 1'b1; val = '1;
                           err_in[ERR_GOLOMB] = 1'b1;
                        end else begin
                           gz_in = gz_ff + 5'd1;
                        end
                     end else begin
                        acc_in = {acc_ff[30:0], bitv};
                        bg_in = bg_ff + 6'd1;
                        if (bg_in >= {1'b0, gz_ff}) begin
                           done = 1'b1; val = acc_in - 32'd1;
                        end
                     end
                  end else if (w != W_END) begin
                     acc_in = {acc_ff[30:0], bitv};
                     bg_in = bg_ff + 6'd1;
                     if (bg_in >= w) begin
                        done = 1'b1; val = acc_in;
                     end
                  end
                  if (done) begin
                     // an earlier result of this byte is not the last one
                     if (pend_ff) begin
                        ov_in = 1'b1;
                        res_in = pres_ff;
                     end
                     pend_in = 1'b1;
                     pres_in = '{is_verdict: 1'b0, id: idx_ff, value: val,
                                 hvalid: 1'b0, flags: 15'd0, last: 1'b0};
                     idx_in = idx_ff + 5'd1; bg_in = 6'd0; acc_in = 32'd0;
                     gz_in = 5'd0;
                     case (it_ff.kind)
                        KIND_SEQ: begin
                           case (idx_ff)
                              5'd0: begin hw_en = 1'b1; hw_addr = 3'd0; end
                              5'd1: lvl_in = val[7:0];
                              5'd2: begin hw_en = 1'b1; hw_addr = 3'd1; end
                              5'd3: ht_in = val[13:0];
                              5'd4: begin hw_en = 1'b1; hw_addr = 3'd2; end
                              5'd5: begin hw_en = 1'b1; hw_addr = 3'd3; end
                              5'd6: begin hw_en = 1'b1; hw_addr = 3'd4; end
                              5'd7: begin hw_en = 1'b1; hw_addr = 3'd5; end
                              5'd11: ld_in = val[0];
                              5'd13: begin hw_en = 1'b1; hw_addr = 3'd6; end
                              default: hw_en = 1'b0;
                           endcase
                           hw_data = val[17:0];
                        end
                        KIND_IPIC: begin
                           hw_data = {17'd0, val[0]};
                           if (idx_ff == 5'd1) begin hw_en = 1'b1; hw_addr = 3'd0; end
                           else if (idx_ff == 5'd2) begin
                              if (val[22:18] > 5'd23 || val[17:12] > 6'd59 ||
                                  val[11:6] > 6'd59 || val[5:0] > 6'd59)
                                 err_in[ERR_TIMECODE] = 1'b1;
                           end else if (idx_ff == 5'd6) fqp_in = val[0];
                           else if (idx_ff == 5'd9) begin hw_en = 1'b1; hw_addr = 3'd1; end
                        end
                        KIND_PBPIC: begin
                           hw_data = {17'd0, val[0]};
                           if (idx_ff == 5'd5) fqp_in = val[0];
                           else if (idx_ff == 5'd7 && val[0]) err_in[ERR_REFFLAG] = 1'b1;
                           else if (idx_ff == 5'd9) begin hw_en = 1'b1; hw_addr = 3'd1; end
                        end
                        default: begin
                           hw_data = val[17:0];
                           if (idx_ff == 5'd0) begin hw_en = 1'b1; hw_addr = 3'd0; end
                           else if (idx_ff == 5'd1) begin hw_en = 1'b1; hw_addr = 3'd1; end
                        end
                     endcase
                  end
                  bit_in = bit_ff - 3'd1;
                  if (bit_ff == 3'd0) begin
                     if (it_ff.last) st_in = ST_VERD;
                     else st_in = ST_IDLE;
                  end
               end
            end
         end
         ST_VERD: begin
            if (w == W_ABSENT) begin
               idx_in = idx_ff + 5'd1;
            end else if (out_free) begin
               if (pend_ff) begin
                  // last element of the byte goes out ahead of the verdict
                  ov_in = 1'b1;
                  res_in = pres_ff;
                  pend_in = 1'b0;
               end else begin
                  if (w != W_END) flags[ERR_TRUNC] = 1'b1;
                  else if (it_ff.kind == KIND_SEQ) begin
                     if (held_ff[0] != 18'h20) flags[0] = 1'b1;
                     if (held_ff[3] != 18'd1) flags[7] = 1'b1;
                     if (held_ff[4] == 18'd0 || held_ff[4] > 18'd4) flags[8] = 1'b1;
                     if (held_ff[5] < 18'd1 || held_ff[5] > 18'd8) flags[9] = 1'b1;
                     if (held_ff[1] == 18'd0 || held_ff[1][0]) flags[2] = 1'b1;
                     if (ht_ff == 14'd0 || ht_ff[0]) flags[3] = 1'b1;
                     if (lvl_ff == 8'h10) begin
                        wlim = 32'd720; hlim = 32'd576; blim = 32'd1228800;
                     end else if (lvl_ff == 8'h20) begin
                        wlim = 32'd1920; hlim = 32'd1152; blim = 32'd2457600;
                     end else begin
                        wlim = 32'd4096; hlim = 32'd2048; blim = 32'd249954304;
                     end
                     if (lvl_ff != 8'h10 && lvl_ff != 8'h20 && lvl_ff != 8'h40)
                        flags[1] = 1'b1;
                     else begin
                        if ({14'd0, held_ff[1]} > wlim || {18'd0, ht_ff} > hlim)
                           flags[4] = 1'b1;
                        if (held_ff[2] != 18'd1) flags[5] = 1'b1;
                        if ({14'd0, held_ff[6]} > blim) flags[6] = 1'b1;
                     end
                  end else if (it_ff.kind == KIND_SLICE) begin
                     // 11 bits: low row plus extension can pass 1023
                     srow = {3'd0, held_ff[0][7:0]};
                     if (hot_ff) srow = srow + {1'b0, held_ff[1][2:0], 7'd0};
                     if (srow != {1'b0, it_ff.row}) flags[ERR_ROW] = 1'b1;
                  end
                  ov_in = 1'b1;
                  res_in = '{is_verdict: 1'b1, id: 5'd0, value: 32'd0,
                             hvalid: (flags == 15'd0), flags: flags, last: 1'b1};
                  idx_in = 5'd0; bg_in = 6'd0; acc_in = 32'd0; gz_in = 5'd0;
                  err_in = 15'd0;
                  st_in = ST_IDLE;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; idx_ff <= 5'd0; bg_ff <= 6'd0; acc_ff <= 32'd0;
         gz_ff <= 5'd0; ld_ff <= 1'b0; ht_ff <= 14'd0; lvl_ff <= 8'd0;
         fqp_ff <= 1'b0; err_ff <= 15'd0; ov_ff <= 1'b0; hot_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         st_ff <= st_in; idx_ff <= idx_in; bg_ff <= bg_in; acc_ff <= acc_in;
         gz_ff <= gz_in; ld_ff <= ld_in; ht_ff <= ht_in; lvl_ff <= lvl_in;
         fqp_ff <= fqp_in; err_ff <= err_in; ov_ff <= ov_in; hot_ff <= hot_in;
         pend_ff <= pend_in;
      end
      it_ff <= it_in; bit_ff <= bit_in; res_ff <= res_in; pres_ff <= pres_in;
      if (hw_en) held_ff[hw_addr] <= hw_data;
   end
endmodule
`default_nettype wire

>>> rtl/vhpc_checker.sv
// ---------------------------------------------------------------------------
// vhpc_checker
// Port-level checks of the parse/check unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module vhpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_is_verdict,
   input wire logic [4:0]  rsp_element_id,
   input wire logic [31:0] rsp_element_value,
   input wire logic        rsp_header_valid,
   input wire logic [14:0] rsp_error_flags,
   input wire logic        rsp_last_result
);
   `CHK_IMPLY(a_verdict_valid, clock, reset, rsp_valid && rsp_is_verdict,
      rsp_header_valid == (rsp_error_flags == 15'd0), "verdict valid mismatch")
   `CHK_IMPLY(a_elem_clean, clock, reset, rsp_valid && !rsp_is_verdict,
      !rsp_header_valid && rsp_error_flags == 15'd0, "element carries flags")
   `CHK_IMPLY(a_verdict_last, clock, reset, rsp_valid && rsp_is_verdict,
      rsp_last_result && rsp_element_id == 5'd0, "verdict not last")
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_element_value), "stalled result changed")
endmodule

bind video_header_parse_check_unit vhpc_checker u_vhpc_checker (.*);
`default_nettype wire
